@@ sv/duart_pkg.sv @@
package duart_pkg;

    // Receive FIFO depth per channel and channel count
    localparam int RX_FIFO_DEPTH = 3;
    localparam int NUM_CHANNELS  = 2;
    localparam int FILL_W        = $clog2(RX_FIFO_DEPTH + 1);

    // Item kinds on the input channel
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    // Register byte offsets
    localparam logic [5:0] REG_CFG_HI     = 6'h00;
    localparam logic [5:0] REG_CFG_LO     = 6'h01;
    localparam logic [5:0] REG_IRQ_LEVEL  = 6'h04;
    localparam logic [5:0] REG_IRQ_VECTOR = 6'h05;
    localparam logic [5:0] REG_MR1_A      = 6'h10;
    localparam logic [5:0] REG_SR_A       = 6'h11;
    localparam logic [5:0] REG_CR_A       = 6'h12;
    localparam logic [5:0] REG_TB_A       = 6'h13;
    localparam logic [5:0] REG_ISR        = 6'h15;
    localparam logic [5:0] REG_MR1_B      = 6'h18;
    localparam logic [5:0] REG_SR_B       = 6'h19;
    localparam logic [5:0] REG_CR_B       = 6'h1A;
    localparam logic [5:0] REG_TB_B       = 6'h1B;
    localparam logic [5:0] REG_OPCR       = 6'h1D;
    localparam logic [5:0] REG_OP_SET     = 6'h1E;
    localparam logic [5:0] REG_OP_CLR     = 6'h1F;
    localparam logic [5:0] REG_MR2_A      = 6'h20;
    localparam logic [5:0] REG_MR2_B      = 6'h21;

    // Command register: low nibble bits, high nibble misc codes
    localparam int CR_RX_ON  = 0;
    localparam int CR_RX_OFF = 1;
    localparam int CR_TX_ON  = 2;
    localparam int CR_TX_OFF = 3;
    localparam logic [3:0] MISC_RESET_RX  = 4'd2;
    localparam logic [3:0] MISC_RESET_TX  = 4'd3;
    localparam logic [3:0] MISC_RESET_ERR = 4'd4;

    // Mode register bits
    localparam int MR1_RX_IRQ_FULL = 6;
    localparam int MR2_LOOPBACK    = 7;

    // Output port: TX handshake pins at 6/7, RX at 4/5 (A then B)
    localparam int OP_TX_BASE = 6;
    localparam int OP_RX_BASE = 4;

    // Interrupt status: TxA 0, RxA 1, TxB 4, RxB 5
    localparam int IRQ_TX_BIT    = 0;
    localparam int IRQ_RX_BIT    = 1;
    localparam int IRQ_CH_STRIDE = 4;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] offset;
        logic [7:0] data;
        logic       channel;
    } duart_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] output_port;
        logic [7:0] interrupt_status;
        logic       tx_valid_a;
        logic [7:0] tx_byte_a;
        logic       tx_valid_b;
        logic [7:0] tx_byte_b;
    } duart_out_t;

    // Per-channel operation strobes for one beat
    typedef struct packed {
        logic push_rx;
        logic pop_rx;
        logic cmd_wr;
        logic tx_wr;
        logic mr1_wr;
        logic mr2_wr;
        logic tick;
    } chan_op_t;

    // Per-channel view returned to the shared logic
    typedef struct packed {
        logic [7:0] mode_one;
        logic [7:0] mode_two;
        logic [7:0] status;
        logic [7:0] pop_byte;
        logic       tx_irq_next;
        logic       rx_irq_next;
        logic       hs_fire;
        logic       hs_tx_pin;
        logic       hs_rx_pin;
        logic       tx_fire;
        logic [7:0] tx_byte;
    } chan_info_t;

endpackage

@@ sv/duart_chan.sv @@
module duart_chan (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  duart_pkg::chan_op_t   op,
    input  logic [7:0]            op_data,
    output duart_pkg::chan_info_t info
);

    localparam int D  = duart_pkg::RX_FIFO_DEPTH;
    localparam int FW = duart_pkg::FILL_W;

    logic [7:0]    mode_one_reg, mode_one_next;
    logic [7:0]    mode_two_reg, mode_two_next;
    logic          rx_en_reg, rx_en_next;
    logic          tx_en_reg, tx_en_next;
    logic          txrdy_reg, txrdy_next;
    logic          overrun_reg, overrun_next;
    logic          rx_irq_reg, rx_irq_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    hold_byte_reg, hold_byte_next;
    logic          hold_full_reg, hold_full_next;
    logic [7:0]    send_byte_reg, send_byte_next;
    logic          send_pending_reg, send_pending_next;
    logic [7:0]    fifo_reg [D];
    logic [7:0]    fifo_next [D];

    logic       push;
    logic       rx_eval;
    logic       hs_fire;
    logic       tx_fire;
    logic [7:0] tx_byte;
    logic [7:0] pop_byte;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_one_reg     <= '0;
            mode_two_reg     <= '0;
            rx_en_reg        <= 1'b0;
            tx_en_reg        <= 1'b0;
            txrdy_reg        <= 1'b0;
            overrun_reg      <= 1'b0;
            rx_irq_reg       <= 1'b0;
            fill_reg         <= '0;
            hold_full_reg    <= 1'b0;
            send_pending_reg <= 1'b0;
        end else begin
            mode_one_reg     <= mode_one_next;
            mode_two_reg     <= mode_two_next;
            rx_en_reg        <= rx_en_next;
            tx_en_reg        <= tx_en_next;
            txrdy_reg        <= txrdy_next;
            overrun_reg      <= overrun_next;
            rx_irq_reg       <= rx_irq_next;
            fill_reg         <= fill_next;
            hold_full_reg    <= hold_full_next;
            send_pending_reg <= send_pending_next;
        end
    end

    // Byte storage, no reset needed
    always_ff @(posedge aclk) begin
        hold_byte_reg <= hold_byte_next;
        send_byte_reg <= send_byte_next;
        for (int i = 0; i < D; i++) begin
            fifo_reg[i] <= fifo_next[i];
        end
    end

    // Next state for one beat
    always_comb begin
        mode_one_next     = mode_one_reg;
        mode_two_next     = mode_two_reg;
        rx_en_next        = rx_en_reg;
        tx_en_next        = tx_en_reg;
        txrdy_next        = txrdy_reg;
        overrun_next      = overrun_reg;
        rx_irq_next       = rx_irq_reg;
        fill_next         = fill_reg;
        hold_byte_next    = hold_byte_reg;
        hold_full_next    = hold_full_reg;
        send_byte_next    = send_byte_reg;
        send_pending_next = send_pending_reg;
        for (int i = 0; i < D; i++) begin
            fifo_next[i] = fifo_reg[i];
        end
        rx_eval  = 1'b0;
        hs_fire  = 1'b0;
        tx_fire  = 1'b0;
        tx_byte  = '0;
        pop_byte = '0;

        // in loopback a transmit write lands in our own receiver
        push = op.push_rx || (op.tx_wr && mode_two_reg[duart_pkg::MR2_LOOPBACK]);

        if (op.mr1_wr) begin
            mode_one_next = op_data;
        end
        if (op.mr2_wr) begin
            mode_two_next = op_data;
        end

        // receive: FIFO, then holding register, then overrun
        if (push && rx_en_reg) begin
            if (fill_reg < FW'(D)) begin
                for (int i = 0; i < D; i++) begin
                    if (FW'(i) == fill_reg) begin
                        fifo_next[i] = op_data;
                    end
                end
                fill_next = fill_reg + FW'(1);
            end else if (!hold_full_reg) begin
                hold_byte_next = op_data;
                hold_full_next = 1'b1;
            end else begin
                overrun_next = 1'b1;
            end
            rx_eval = 1'b1;
            hs_fire = 1'b1;
        end

        // pop: shift down, holding byte refills the top slot
        if (op.pop_rx) begin
            if (fill_reg != '0) begin
                pop_byte = fifo_reg[0];
                for (int i = 0; i < D - 1; i++) begin
                    fifo_next[i] = fifo_reg[i + 1];
                end
                if (hold_full_reg) begin
                    fifo_next[D - 1] = hold_byte_reg;
                    hold_full_next   = 1'b0;
                end else begin
                    fill_next = fill_reg - FW'(1);
                end
            end
            rx_eval = 1'b1;
            hs_fire = 1'b1;
        end

        if (rx_eval) begin
            rx_irq_next = mode_one_reg[duart_pkg::MR1_RX_IRQ_FULL] ?
                          (fill_next >= FW'(D)) : (fill_next != '0);
        end

        // command register
        if (op.cmd_wr) begin
            if (op_data[duart_pkg::CR_RX_ON]) begin
                rx_en_next = 1'b1;
            end
            if (op_data[duart_pkg::CR_RX_OFF]) begin
                rx_en_next = 1'b0;
            end
            if (op_data[duart_pkg::CR_TX_ON]) begin
                tx_en_next = 1'b1;
                txrdy_next = 1'b1;
            end
            if (op_data[duart_pkg::CR_TX_OFF]) begin
                tx_en_next = 1'b0;
                txrdy_next = 1'b0;
            end
            unique case (op_data[7:4])
                duart_pkg::MISC_RESET_RX: begin
                    rx_en_next     = 1'b0;
                    fill_next      = '0;
                    hold_full_next = 1'b0;
                    rx_irq_next    = 1'b0;
                end
                duart_pkg::MISC_RESET_TX: begin
                    tx_en_next        = 1'b0;
                    send_pending_next = 1'b0;
                    txrdy_next        = 1'b0;
                end
                duart_pkg::MISC_RESET_ERR: begin
                    overrun_next = 1'b0;
                end
                default: begin
                end
            endcase
            hs_fire = 1'b1;
        end

        // transmit write queues a byte for the next tick
        if (op.tx_wr && !mode_two_reg[duart_pkg::MR2_LOOPBACK] && tx_en_reg) begin
            send_byte_next    = op_data;
            send_pending_next = 1'b1;
            txrdy_next        = 1'b0;
            hs_fire           = 1'b1;
        end

        // tick sends the queued byte
        if (op.tick && send_pending_reg) begin
            tx_fire           = 1'b1;
            tx_byte           = send_byte_reg;
            send_pending_next = 1'b0;
            txrdy_next        = 1'b1;
            hs_fire           = 1'b1;
        end
    end

    // Status: overrun, TxEMP, TxRDY, FFULL, RxRDY from bit 4 down
    always_comb begin
        info.mode_one    = mode_one_reg;
        info.mode_two    = mode_two_reg;
        info.status      = {3'b000, overrun_reg, txrdy_reg, txrdy_reg,
                            fill_reg == FW'(D), fill_reg != '0};
        info.pop_byte    = pop_byte;
        info.tx_irq_next = txrdy_next;
        info.rx_irq_next = rx_irq_next;
        info.hs_fire     = hs_fire;
        info.hs_tx_pin   = (mode_two_next[duart_pkg::MR2_LOOPBACK] && fill_next != '0)
                           || !txrdy_next;
        info.hs_rx_pin   = (fill_next == '0);
        info.tx_fire     = tx_fire;
        info.tx_byte     = tx_byte;
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(D))
        else $error("rx fill beyond FIFO depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        hold_full_reg |-> fill_reg == FW'(D))
        else $error("holding register full while FIFO has room");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (op.pop_rx && hold_full_reg && !op.cmd_wr) |=> fill_reg == FW'(D) && !hold_full_reg)
        else $error("pop with held byte did not refill FIFO");

    assert property (@(posedge aclk) disable iff (!aresetn)
        tx_fire |=> txrdy_reg && !send_pending_reg)
        else $error("transmitter not ready after sending a byte");
`endif

endmodule

@@ sv/dual_uart_register_block.sv @@
// Two-channel DUART-style register block. Each beat on s_ is one bus read,
// bus write, received byte (s_data.channel picks A or B) or tick, and yields
// exactly one result beat on m_ with read data, output port, interrupt status
// and any byte sent on the tick. The block takes one beat per clock while m_
// is not stalled: a beat is captured in the input register, and all register,
// FIFO and handshake updates are written with its result into the result
// register once the result register is free. While a result waits on m_ready
// the result register holds, the input register takes at most one more beat,
// and then s_ready drops until the result leaves. Each channel has a
// three-deep receive FIFO plus a holding byte; a further byte sets overrun.
// Reads of the transmit/receive offset pop the FIFO.
module dual_uart_register_block (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  duart_pkg::duart_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output duart_pkg::duart_out_t m_data
);

    localparam int NCH = duart_pkg::NUM_CHANNELS;

    logic                  in_valid_reg, in_valid_next;
    duart_pkg::duart_in_t  in_item_reg;
    logic                  out_valid_reg, out_valid_next;
    duart_pkg::duart_out_t result_reg, result_next;

    logic [15:0] module_cfg_reg, module_cfg_next;
    logic [7:0]  irq_level_reg, irq_level_next;
    logic [7:0]  irq_vector_reg, irq_vector_next;
    logic [7:0]  out_config_reg, out_config_next;
    logic [7:0]  out_port_reg, out_port_next;

    logic out_free;
    logic advance;
    logic is_rd, is_wr, is_rx, is_tick;
    logic wr_opcr;
    logic [7:0] irq_next;
    logic [7:0] read_data;

    duart_pkg::chan_op_t   ops   [NCH];
    duart_pkg::chan_info_t infos [NCH];

    // Beat handshake: input register feeds result register
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = result_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            module_cfg_reg <= '0;
            irq_level_reg  <= '0;
            irq_vector_reg <= '0;
            out_config_reg <= '0;
            out_port_reg   <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            module_cfg_reg <= module_cfg_next;
            irq_level_reg  <= irq_level_next;
            irq_vector_reg <= irq_vector_next;
            out_config_reg <= out_config_next;
            out_port_reg   <= out_port_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // Item kind, only while the beat moves on
    assign is_rd   = advance && in_item_reg.command == duart_pkg::CMD_READ;
    assign is_wr   = advance && in_item_reg.command == duart_pkg::CMD_WRITE;
    assign is_rx   = advance && in_item_reg.command == duart_pkg::CMD_RX;
    assign is_tick = advance && in_item_reg.command == duart_pkg::CMD_TICK;
    assign wr_opcr = is_wr && in_item_reg.offset == duart_pkg::REG_OPCR;

    // Channels
    for (genvar c = 0; c < NCH; c++) begin : g_chan
        localparam logic [5:0] OFF_MR1 = (c == 0) ? duart_pkg::REG_MR1_A : duart_pkg::REG_MR1_B;
        localparam logic [5:0] OFF_CR  = (c == 0) ? duart_pkg::REG_CR_A  : duart_pkg::REG_CR_B;
        localparam logic [5:0] OFF_TB  = (c == 0) ? duart_pkg::REG_TB_A  : duart_pkg::REG_TB_B;
        localparam logic [5:0] OFF_MR2 = (c == 0) ? duart_pkg::REG_MR2_A : duart_pkg::REG_MR2_B;

        assign ops[c] = '{
            push_rx: is_rx && in_item_reg.channel == 1'(c),
            pop_rx:  is_rd && in_item_reg.offset == OFF_TB,
            cmd_wr:  is_wr && in_item_reg.offset == OFF_CR,
            tx_wr:   is_wr && in_item_reg.offset == OFF_TB,
            mr1_wr:  is_wr && in_item_reg.offset == OFF_MR1,
            mr2_wr:  is_wr && in_item_reg.offset == OFF_MR2,
            tick:    is_tick
        };

        duart_chan u_chan (
            .aclk    (aclk),
            .aresetn (aresetn),
            .op      (ops[c]),
            .op_data (in_item_reg.data),
            .info    (infos[c])
        );
    end

    // Shared registers and output port
    always_comb begin
        module_cfg_next = module_cfg_reg;
        irq_level_next  = irq_level_reg;
        irq_vector_next = irq_vector_reg;
        out_config_next = out_config_reg;
        out_port_next   = out_port_reg;

        if (is_wr) begin
            unique case (in_item_reg.offset)
                duart_pkg::REG_CFG_HI:     module_cfg_next[15:8] = in_item_reg.data;
                duart_pkg::REG_CFG_LO:     module_cfg_next[7:0]  = in_item_reg.data;
                duart_pkg::REG_IRQ_LEVEL:  irq_level_next        = in_item_reg.data;
                duart_pkg::REG_IRQ_VECTOR: irq_vector_next       = in_item_reg.data;
                duart_pkg::REG_OPCR:       out_config_next       = in_item_reg.data;
                duart_pkg::REG_OP_SET:     out_port_next = out_port_reg | in_item_reg.data;
                duart_pkg::REG_OP_CLR:     out_port_next = out_port_reg & ~in_item_reg.data;
                default: begin
                end
            endcase
        end

        // handshake pins follow channel state where routed
        for (int c = 0; c < NCH; c++) begin
            if (infos[c].hs_fire || wr_opcr) begin
                if (out_config_next[duart_pkg::OP_TX_BASE + c]) begin
                    out_port_next[duart_pkg::OP_TX_BASE + c] = infos[c].hs_tx_pin;
                end
                if (out_config_next[duart_pkg::OP_RX_BASE + c]) begin
                    out_port_next[duart_pkg::OP_RX_BASE + c] = infos[c].hs_rx_pin;
                end
            end
        end

        // interrupt status; break bits are never set
        irq_next = '0;
        for (int c = 0; c < NCH; c++) begin
            irq_next[duart_pkg::IRQ_CH_STRIDE * c + duart_pkg::IRQ_TX_BIT] =
                infos[c].tx_irq_next;
            irq_next[duart_pkg::IRQ_CH_STRIDE * c + duart_pkg::IRQ_RX_BIT] =
                infos[c].rx_irq_next;
        end
    end

    // Read mux
    always_comb begin
        read_data = '0;
        if (is_rd) begin
            unique case (in_item_reg.offset)
                duart_pkg::REG_CFG_HI:     read_data = module_cfg_reg[15:8];
                duart_pkg::REG_CFG_LO:     read_data = module_cfg_reg[7:0];
                duart_pkg::REG_IRQ_LEVEL:  read_data = irq_level_reg;
                duart_pkg::REG_IRQ_VECTOR: read_data = irq_vector_reg;
                duart_pkg::REG_MR1_A:      read_data = infos[0].mode_one;
                duart_pkg::REG_SR_A:       read_data = infos[0].status;
                duart_pkg::REG_TB_A:       read_data = infos[0].pop_byte;
                duart_pkg::REG_ISR:        read_data = irq_next;
                duart_pkg::REG_MR1_B:      read_data = infos[1].mode_one;
                duart_pkg::REG_SR_B:       read_data = infos[1].status;
                duart_pkg::REG_TB_B:       read_data = infos[1].pop_byte;
                duart_pkg::REG_MR2_A:      read_data = infos[0].mode_two;
                duart_pkg::REG_MR2_B:      read_data = infos[1].mode_two;
                default:                   read_data = '0;
            endcase
        end
    end

    // Result beat
    always_comb begin
        result_next.read_data        = read_data;
        result_next.output_port      = out_port_next;
        result_next.interrupt_status = irq_next;
        result_next.tx_valid_a       = infos[0].tx_fire;
        result_next.tx_byte_a        = infos[0].tx_byte;
        result_next.tx_valid_b       = infos[1].tx_fire;
        result_next.tx_byte_b        = infos[1].tx_byte;
    end

endmodule
